// ----- rtl/hcc_pkg.sv -----
// shared constants, field layout and width helpers for the height map cutter
package hcc_pkg;

    localparam int GRID_MAX_DEF     = 128;
    localparam int HEIGHT_BITS_DEF  = 16;
    localparam int MAX_DIAMETER_DEF = 127;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 1'b1;

    localparam logic [CFG_DATA_W-1:0] GRID_RESET = 8'd128;

    localparam logic CMD_FILL = 1'b0;
    localparam logic CMD_CUT  = 1'b1;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;
    localparam int HEIGHT_IN_W = 16;
    localparam int DIAM_W    = 7;
    localparam int VOLUME_W  = 30;
    localparam int CELLS_W   = 15;

    localparam logic [VOLUME_W-1:0] VOLUME_MAX = 30'h3FFF_FFFF;
    localparam logic [CELLS_W-1:0]  CELLS_MAX  = 15'h7FFF;

    // bits for a grid coordinate, able to hold the grid size itself
    function automatic int coord_w(input int grid_max);
        return $clog2(grid_max + 1);
    endfunction

    function automatic int rad_w(input int max_rad);
        return (max_rad < 1) ? 1 : $clog2(max_rad + 1);
    endfunction

    // is_cut, height, two centres, box corners, y size, radius
    function automatic int desc_w(input int hb, input int cw, input int rw);
        return 1 + hb + 32 + 5 * cw + rw;
    endfunction

endpackage

// ----- rtl/hcc_ram.sv -----
// generic simple dual port ram, one write port, one registered read port
module hcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/hcc_queue.sv -----
// short command queue between the front and back parts
module hcc_queue import hcc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

// ----- rtl/hcc_front.sv -----
// front part: grid size registers, input accept and cut box classification
module hcc_front import hcc_pkg::*; #(
    parameter int GRID_MAX     = GRID_MAX_DEF,
    parameter int HEIGHT_BITS  = HEIGHT_BITS_DEF,
    parameter int MAX_DIAMETER = MAX_DIAMETER_DEF,
    localparam int CW     = coord_w(GRID_MAX),
    localparam int RW     = rad_w(MAX_DIAMETER / 2),
    localparam int DESC_W = desc_w(HEIGHT_BITS, CW, RW)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  clear_busy,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [DESC_W-1:0]     q_wdata
);

    localparam int HW = HEIGHT_BITS;
    localparam int XW = (HW > HEIGHT_IN_W) ? HW : HEIGHT_IN_W;

    typedef struct packed {
        logic                is_cut;
        logic [HW-1:0]       hgt;
        logic signed [15:0]  cx;
        logic signed [15:0]  cy;
        logic [CW-1:0]       x0;
        logic [CW-1:0]       x1;
        logic [CW-1:0]       y0;
        logic [CW-1:0]       y1;
        logic [CW-1:0]       ys;
        logic [RW-1:0]       rad;
    } desc_t;

    logic [CFG_DATA_W-1:0] grid_x_reg, grid_x_next;
    logic [CFG_DATA_W-1:0] grid_y_reg, grid_y_next;

    logic signed [15:0]  cx;
    logic signed [15:0]  cy;
    logic [DIAM_W-1:0]   diam;
    logic [XW-1:0]       h_ext;
    logic [RW-1:0]       rad;
    logic [CW-1:0]       xs;
    logic [CW-1:0]       ys;
    logic signed [17:0]  rad_w18;
    desc_t               desc;

    function automatic logic [CW-1:0] clamp_box(input logic signed [17:0] v,
                                                 input logic [CW-1:0] hi);
        logic [CW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > signed'(18'(hi))) begin
            res = hi;
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    always_comb begin
        grid_x_next = grid_x_reg;
        grid_y_next = grid_y_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_GRID_X: grid_x_next = cfg_data;
                REG_GRID_Y: grid_y_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_x_reg <= GRID_RESET;
            grid_y_reg <= GRID_RESET;
        end else begin
            grid_x_reg <= grid_x_next;
            grid_y_reg <= grid_y_next;
        end
    end

    assign cfg_ready = 1'b1;

    assign cx    = signed'(s_tdata[15:0]);
    assign cy    = signed'(s_tdata[31:16]);
    assign diam  = s_tdata[38:32];
    assign h_ext = XW'(s_tdata[54:39]);

    assign xs = (32'(grid_x_reg) > GRID_MAX) ? CW'(GRID_MAX) : CW'(grid_x_reg);
    assign ys = (32'(grid_y_reg) > GRID_MAX) ? CW'(GRID_MAX) : CW'(grid_y_reg);

    assign rad = (32'(diam) > MAX_DIAMETER) ? RW'(MAX_DIAMETER / 2) : RW'(diam >> 1);
    assign rad_w18 = signed'(18'(rad));

    always_comb begin
        desc.is_cut = (s_tuser == CMD_CUT);
        desc.hgt    = (h_ext > XW'({HW{1'b1}})) ? {HW{1'b1}} : HW'(h_ext);
        desc.cx     = cx;
        desc.cy     = cy;
        desc.x0     = clamp_box(18'(cx) - rad_w18, xs);
        desc.x1     = clamp_box(18'(cx) + rad_w18, xs);
        desc.y0     = clamp_box(18'(cy) - rad_w18, ys);
        desc.y1     = clamp_box(18'(cy) + rad_w18, ys);
        desc.ys     = ys;
        desc.rad    = rad;
    end

    assign s_tready = !q_full && !clear_busy;
    assign q_push   = s_tvalid && s_tready;
    assign q_wdata  = desc;

endmodule

// ----- rtl/hcc_back.sv -----
// back part: height map memory, clearing pass, fill sweep and cut scan
module hcc_back import hcc_pkg::*; #(
    parameter int GRID_MAX     = GRID_MAX_DEF,
    parameter int HEIGHT_BITS  = HEIGHT_BITS_DEF,
    parameter int MAX_DIAMETER = MAX_DIAMETER_DEF,
    localparam int CW     = coord_w(GRID_MAX),
    localparam int RW     = rad_w(MAX_DIAMETER / 2),
    localparam int DESC_W = desc_w(HEIGHT_BITS, CW, RW)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  logic [DESC_W-1:0]    q_rdata,
    output logic                 q_pop,
    output logic                 clear_busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int HW    = HEIGHT_BITS;
    localparam int DW    = RW + 1;
    localparam int SQW   = 2 * RW;
    localparam int CELLS = GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(CELLS);
    localparam int VSW   = ((HW > VOLUME_W) ? HW : VOLUME_W) + 1;

    typedef struct packed {
        logic                is_cut;
        logic [HW-1:0]       hgt;
        logic signed [15:0]  cx;
        logic signed [15:0]  cy;
        logic [CW-1:0]       x0;
        logic [CW-1:0]       x1;
        logic [CW-1:0]       y0;
        logic [CW-1:0]       y1;
        logic [CW-1:0]       ys;
        logic [RW-1:0]       rad;
    } desc_t;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b000_0001,
        ST_IDLE  = 7'b000_0010,
        ST_SETUP = 7'b000_0100,
        ST_FILL  = 7'b000_1000,
        ST_CUT   = 7'b001_0000,
        ST_DRAIN = 7'b010_0000,
        ST_DONE  = 7'b100_0000
    } state_t;

    state_t              state_reg, state_next;
    desc_t               d_reg, d_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       x_reg, x_next;
    logic [CW-1:0]       y_reg, y_next;
    logic [AW-1:0]       rb_reg, rb_next;
    logic signed [DW-1:0] dx_reg, dx_next;
    logic signed [DW-1:0] dy_reg, dy_next;
    logic signed [DW-1:0] dy0_reg, dy0_next;
    logic [SQW-1:0]      r2_reg, r2_next;
    logic                p_valid_reg, p_valid_next;
    logic                p_in_reg, p_in_next;
    logic [AW-1:0]       p_addr_reg, p_addr_next;
    logic [VOLUME_W-1:0] vol_reg, vol_next;
    logic [CELLS_W-1:0]  cells_reg, cells_next;
    logic                m_valid_reg, m_valid_next;
    logic [VOLUME_W-1:0] m_vol_reg, m_vol_next;
    logic [CELLS_W-1:0]  m_cells_reg, m_cells_next;

    logic [2*CW-1:0]      prod;
    logic signed [17:0]   dx0_w;
    logic signed [17:0]   dy0_w;
    logic signed [2*DW-1:0] sqx;
    logic signed [2*DW-1:0] sqy;
    logic [SQW:0]         sq_sum;
    logic                 in_circle;
    logic                 last_x;
    logic                 last_y;
    logic                 box_empty;
    logic                 hit;
    logic [HW-1:0]        diff;
    logic [VSW-1:0]       vol_sum;
    logic                 out_free;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [HW-1:0]        wr_data;
    logic [AW-1:0]        rd_addr;
    logic [HW-1:0]        rd_data;

    hcc_ram #(
        .WIDTH (HW),
        .DEPTH (CELLS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign prod  = d_reg.x0 * d_reg.ys;
    assign dx0_w = signed'(18'(d_reg.x0)) - 18'(d_reg.cx);
    assign dy0_w = signed'(18'(d_reg.y0)) - 18'(d_reg.cy);

    assign sqx       = dx_reg * dx_reg;
    assign sqy       = dy_reg * dy_reg;
    assign sq_sum    = (SQW + 1)'(sqx[SQW-1:0]) + (SQW + 1)'(sqy[SQW-1:0]);
    assign in_circle = sq_sum < {1'b0, r2_reg};

    assign last_x    = (x_reg + 1'b1) == d_reg.x1;
    assign last_y    = (y_reg + 1'b1) == d_reg.y1;
    assign box_empty = (d_reg.x0 == d_reg.x1) || (d_reg.y0 == d_reg.y1);

    assign rd_addr = rb_reg + AW'(y_reg);

    assign hit     = p_valid_reg && p_in_reg && (rd_data > d_reg.hgt);
    assign diff    = rd_data - d_reg.hgt;
    assign vol_sum = VSW'(vol_reg) + VSW'(diff);

    assign out_free = !m_valid_reg || m_tready;

    // write port: clearing pass, fill sweep, or cut write-back
    always_comb begin
        wr_en   = hit;
        wr_addr = p_addr_reg;
        wr_data = d_reg.hgt;
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = '0;
        end else if (state_reg == ST_FILL) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        d_next       = d_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        rb_next      = rb_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dy0_next     = dy0_reg;
        r2_next      = r2_reg;
        p_valid_next = 1'b0;
        p_in_next    = in_circle;
        p_addr_next  = rd_addr;
        vol_next     = vol_reg;
        cells_next   = cells_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_vol_next   = m_vol_reg;
        m_cells_next = m_cells_reg;
        q_pop        = 1'b0;

        if (hit) begin
            vol_next = (vol_sum > VSW'(VOLUME_MAX)) ? VOLUME_MAX : VOLUME_W'(vol_sum);
            if (cells_reg != CELLS_MAX) begin
                cells_next = cells_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    d_next     = q_rdata;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cnt_next   = '0;
                vol_next   = '0;
                cells_next = '0;
                x_next     = d_reg.x0;
                y_next     = d_reg.y0;
                rb_next    = AW'(prod);
                dx_next    = DW'(dx0_w);
                dy_next    = DW'(dy0_w);
                dy0_next   = DW'(dy0_w);
                r2_next    = d_reg.rad * d_reg.rad;
                if (!d_reg.is_cut) begin
                    state_next = ST_FILL;
                end else if (box_empty) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CUT;
                end
            end
            ST_FILL: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(CELLS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_CUT: begin
                p_valid_next = 1'b1;
                if (last_y) begin
                    y_next  = d_reg.y0;
                    dy_next = dy0_reg;
                    x_next  = x_reg + 1'b1;
                    dx_next = dx_reg + 1'b1;
                    rb_next = rb_reg + AW'(d_reg.ys);
                    if (last_x) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    y_next  = y_reg + 1'b1;
                    dy_next = dy_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_vol_next   = vol_reg;
                    m_cells_next = cells_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg       <= d_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        rb_reg      <= rb_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dy0_reg     <= dy0_next;
        r2_reg      <= r2_next;
        p_in_reg    <= p_in_next;
        p_addr_reg  <= p_addr_next;
        vol_reg     <= vol_next;
        cells_reg   <= cells_next;
        m_vol_reg   <= m_vol_next;
        m_cells_reg <= m_cells_next;
    end

    assign clear_busy = (state_reg == ST_CLEAR);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = M_TDATA_W'({m_cells_reg, m_vol_reg});

endmodule

// ----- rtl/heightmap_circular_cutter.sv -----
// top level of the height map milling block with a circular cutter
//
// The block holds a GRID_MAX x GRID_MAX map of stock heights in one RAM, cell
// (x, y) at address x * grid_y_size + y. After reset a clearing pass writes
// zero to every cell (16384 by default), one per cycle; no transaction is taken
// on the input stream meanwhile, while configuration writes are. A fill visits
// every cell of the RAM; a cut scans its clamped box, one cell per cycle. The
// single read and single write port of the map set that pace: each cell is
// read, compared against the cutter circle and height, and written back in the
// following cycle. A two-entry command queue sits in front of the scan, and the
// result register lets the next command start while a result waits.
module heightmap_circular_cutter import hcc_pkg::*; #(
    parameter int GRID_MAX     = GRID_MAX_DEF,
    parameter int HEIGHT_BITS  = HEIGHT_BITS_DEF,
    parameter int MAX_DIAMETER = MAX_DIAMETER_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // center_x[15:0], center_y[31:16], diameter[38:32], height[54:39], zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // cmd[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // removed_volume[29:0], removed_cells[44:30], zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW     = coord_w(GRID_MAX);
    localparam int RW     = rad_w(MAX_DIAMETER / 2);
    localparam int DESC_W = desc_w(HEIGHT_BITS, CW, RW);

    logic              clear_busy;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic [DESC_W-1:0] q_wdata;
    logic [DESC_W-1:0] q_rdata;

    hcc_front #(
        .GRID_MAX     (GRID_MAX),
        .HEIGHT_BITS  (HEIGHT_BITS),
        .MAX_DIAMETER (MAX_DIAMETER)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    hcc_queue #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    hcc_back #(
        .GRID_MAX     (GRID_MAX),
        .HEIGHT_BITS  (HEIGHT_BITS),
        .MAX_DIAMETER (MAX_DIAMETER)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_rdata    (q_rdata),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !(s_tvalid && s_tready))
        else $error("input transaction taken during clearing pass");

    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> clear_busy)
        else $error("clearing pass not started after reset");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !m_tvalid)
        else $error("result offered during clearing pass");

    a_queue_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command queue written while full");

    a_queue_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("command queue read while empty");

endmodule

// ----- dv/tb_heightmap_circular_cutter.sv -----
// self-checking testbench for the height map milling block with a circular cutter
`timescale 1ns / 1ps

module tb_heightmap_circular_cutter;
    import hcc_pkg::*;

    localparam int CELL_COUNT     = GRID_MAX_DEF * GRID_MAX_DEF;
    localparam int FILL_CYCLES    = CELL_COUNT + 3;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int ITEM_BUDGET    = 200;
    localparam int CYCLE_LIMIT    =
        4 * (CELL_COUNT + ITEM_BUDGET * (FILL_CYCLES + RX_HOLD_CYCLES + 64));

    typedef struct packed {
        logic [VOLUME_W-1:0] volume;
        logic [CELLS_W-1:0]  cells;
    } removal_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = CMD_FILL;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_GRID_X;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [HEIGHT_IN_W-1:0] stock_map [CELL_COUNT];
    logic [CFG_DATA_W-1:0]  grid_x = GRID_RESET;
    logic [CFG_DATA_W-1:0]  grid_y = GRID_RESET;
    removal_t               removal_q [$];
    removal_t               rx_want;
    removal_t               rx_got;
    int                     mismatch_count = 0;
    int                     snd_idle_pct   = 0;
    int                     rcv_idle_pct   = 0;
    logic                   rx_hold        = 1'b0;

    heightmap_circular_cutter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int eff_size(input logic [CFG_DATA_W-1:0] sz);
        return (int'(sz) > GRID_MAX_DEF) ? GRID_MAX_DEF : int'(sz);
    endfunction

    function automatic int clamp_coord(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int near_coord(input int size);
        return int'($urandom_range(0, size + 16)) - 8;
    endfunction

    // updates the stock copy and returns the removal caused by one command
    function automatic removal_t mill_item(input logic cmd,
                                           input logic signed [15:0] cx_in,
                                           input logic signed [15:0] cy_in,
                                           input logic [DIAM_W-1:0] diam,
                                           input logic [HEIGHT_IN_W-1:0] h);
        int       xs, ys, r, x0, x1, y0, y1, cx, cy, dx, dy, idx;
        longint   vol;
        int       cells;
        removal_t res;
        vol   = 0;
        cells = 0;
        if (cmd == CMD_FILL) begin
            for (int i = 0; i < CELL_COUNT; i++)
                stock_map[i] = h;
        end else begin
            xs = eff_size(grid_x);
            ys = eff_size(grid_y);
            cx = cx_in;
            cy = cy_in;
            r  = int'(diam) / 2;
            x0 = clamp_coord(cx - r, xs);
            x1 = clamp_coord(cx + r, xs);
            y0 = clamp_coord(cy - r, ys);
            y1 = clamp_coord(cy + r, ys);
            for (int x = x0; x < x1; x++) begin
                for (int y = y0; y < y1; y++) begin
                    dx  = x - cx;
                    dy  = y - cy;
                    idx = x * ys + y;
                    if (idx < CELL_COUNT && dx * dx + dy * dy < r * r &&
                        stock_map[idx] > h) begin
                        vol = vol + longint'(stock_map[idx]) - longint'(h);
                        stock_map[idx] = h;
                        cells++;
                    end
                end
            end
        end
        res.volume = (vol > longint'(VOLUME_MAX)) ? VOLUME_MAX : vol[VOLUME_W-1:0];
        res.cells  = (cells > int'(CELLS_MAX)) ? CELLS_MAX : cells[CELLS_W-1:0];
        return res;
    endfunction

    task automatic note_mismatch(input string what, input removal_t want,
                                 input removal_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch, %s: expected volume %0d cells %0d, got volume %0d cells %0d",
                     what, want.volume, want.cells, got.volume, got.cells);
    endtask

    // result checker and receiver readiness
    always @(posedge aclk) begin
        if (m_tvalid === 1'b1 && m_tready) begin
            rx_got.volume = m_tdata[VOLUME_W-1:0];
            rx_got.cells  = m_tdata[VOLUME_W+CELLS_W-1:VOLUME_W];
            if (removal_q.size() == 0) begin
                note_mismatch("no transaction expected", '0, rx_got);
            end else begin
                rx_want = removal_q.pop_front();
                if (rx_got.volume !== rx_want.volume || rx_got.cells !== rx_want.cells)
                    note_mismatch("result field", rx_want, rx_got);
            end
        end
        m_tready <= rx_hold ? 1'b0 : (int'($urandom_range(0, 99)) >= rcv_idle_pct);
    end

    initial begin
        for (int c = 0; c < CYCLE_LIMIT; c++)
            @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [15:0] cx, input logic [15:0] cy,
                             input logic [DIAM_W-1:0] diam,
                             input logic [HEIGHT_IN_W-1:0] h);
        if (int'($urandom_range(0, 99)) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, h, diam, cy, cx};
        do @(posedge aclk); while (s_tready !== 1'b1);
        removal_q.push_back(mill_item(cmd, cx, cy, diam, h));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (removal_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == REG_GRID_X)
            grid_x = val;
        else
            grid_y = val;
        @(posedge aclk);
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] xs, input logic [CFG_DATA_W-1:0] ys);
        drain_results();
        write_register(REG_GRID_X, xs);
        write_register(REG_GRID_Y, ys);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_grid_size();
        case ($urandom_range(0, 9))
            0:       return 8'd1;
            1:       return 8'd128;
            2:       return 8'd255;
            3:       return 8'($urandom_range(129, 254));
            default: return 8'($urandom_range(8, 128));
        endcase
    endfunction

    task automatic random_item();
        int pick;
        int xs, ys;
        pick = $urandom_range(0, 99);
        xs   = eff_size(grid_x);
        ys   = eff_size(grid_y);
        if (pick < 8)
            send_item(CMD_FILL, 16'($urandom), 16'($urandom), 7'($urandom),
                      16'($urandom));
        else if (pick < 20)
            send_item(CMD_CUT, 16'($urandom), 16'($urandom), 7'($urandom),
                      16'($urandom));
        else if (pick < 25)
            send_item(CMD_CUT, 16'(near_coord(xs)), 16'(near_coord(ys)),
                      7'($urandom_range(64, 127)), 16'($urandom));
        else
            send_item(CMD_CUT, 16'(near_coord(xs)), 16'(near_coord(ys)),
                      7'($urandom_range(0, 24)), 16'($urandom));
    endtask

    // cut on the cleared map after reset removes nothing
    task automatic test_power_on_state();
        send_item(CMD_CUT, 16'sd64, 16'sd64, 7'd127, 16'd0);
    endtask

    task automatic test_fill_and_cut_extremes();
        send_item(CMD_FILL, 16'sd0, 16'sd0, 7'd0, 16'hFFFF);
        send_item(CMD_CUT, 16'sd64, 16'sd64, 7'd127, 16'd0);
        send_item(CMD_CUT, 16'sd64, 16'sd64, 7'd127, 16'd0);
        send_item(CMD_FILL, 16'hFFFF, 16'hFFFF, 7'h7F, 16'd1000);
        send_item(CMD_CUT, 16'sd10, 16'sd10, 7'd0, 16'd0);
        send_item(CMD_CUT, 16'sd10, 16'sd10, 7'd1, 16'd0);
        send_item(CMD_CUT, 16'sd20, 16'sd20, 7'd2, 16'd0);
        send_item(CMD_CUT, 16'sd30, 16'sd30, 7'd3, 16'd0);
        send_item(CMD_CUT, 16'h8000, 16'h7FFF, 7'd127, 16'd0);
        send_item(CMD_CUT, 16'h7FFF, 16'h8000, 7'd127, 16'd0);
        send_item(CMD_CUT, 16'hFFFF, 16'hFFFF, 7'd10, 16'd5);
        send_item(CMD_CUT, 16'sd127, 16'sd127, 7'd20, 16'hFFFF);
        send_item(CMD_CUT, 16'sd127, 16'sd127, 7'd20, 16'd999);
    endtask

    task automatic test_grid_sizes();
        set_grid(8'd0, 8'd128);
        send_item(CMD_CUT, 16'sd0, 16'sd0, 7'd127, 16'd0);
        set_grid(8'd255, 8'd200);
        send_item(CMD_FILL, 16'sd0, 16'sd0, 7'd0, 16'd500);
        send_item(CMD_CUT, 16'sd100, 16'sd100, 7'd90, 16'd7);
        set_grid(8'd1, 8'd1);
        send_item(CMD_CUT, 16'sd0, 16'sd0, 7'd2, 16'd3);
        // fill reaches cells outside the grid in use
        set_grid(8'd8, 8'd8);
        send_item(CMD_FILL, 16'sd0, 16'sd0, 7'd0, 16'd700);
        set_grid(8'd128, 8'd128);
        send_item(CMD_CUT, 16'sd64, 16'sd64, 7'd127, 16'd1);
        set_grid(8'd37, 8'd91);
        send_item(CMD_CUT, 16'sd36, 16'sd90, 7'd30, 16'd100);
    endtask

    // receiver stalls long enough for the command queue to back up
    task automatic test_backpressure();
        set_grid(8'd64, 8'd64);
        send_item(CMD_FILL, 16'sd0, 16'sd0, 7'd0, 16'd30000);
        drain_results();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (12)
            send_item(CMD_CUT, 16'(near_coord(64)), 16'(near_coord(64)),
                      7'($urandom_range(4, 10)), 16'($urandom_range(0, 29999)));
    endtask

    task automatic test_drain_pause();
        repeat (3) random_item();
        drain_results();
        repeat (3) random_item();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle_pct = 20;
                    rcv_idle_pct <= 54;
                end
                1: begin
                    snd_idle_pct = 54;
                    rcv_idle_pct <= 20;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct <= 0;
                end
            endcase
            set_grid(pick_grid_size(), pick_grid_size());
            repeat (20) random_item();
        end
    endtask

    initial begin
        foreach (stock_map[i])
            stock_map[i] = '0;
        snd_idle_pct = 20;
        rcv_idle_pct <= 54;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_power_on_state();
        test_fill_and_cut_extremes();
        test_grid_sizes();
        test_backpressure();
        test_drain_pause();
        test_random();
        drain_results();
        if (mismatch_count == 0 && removal_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
